[hdl/p2n_pkg.sv]
// Package: constants, command/status structs for the pitch-to-note converter.
`default_nettype none
package p2n_pkg;

    localparam int PITCH_W  = 16;
    localparam int NOTE_W   = 7;
    localparam int FINE_W   = 7;
    localparam int NOTE_O_W = 9;
    localparam int FINE_O_W = 8;

    localparam int OCT_W    = 4;
    localparam int CURVE_W  = 14;
    localparam int MUL_W    = 13;
    localparam int SHIFT    = 12;
    localparam int SPAN_W   = CURVE_W + 15;
    localparam int STEP_W   = 5;
    localparam int INC_W    = SPAN_W - STEP_W;
    localparam int SEG_W    = 6;
    localparam int IDX_W    = SEG_W + STEP_W;
    localparam int BPOS_W   = 3;

    localparam logic [CURVE_W-1:0] CURVE_START = 14'h1000;
    localparam logic [MUL_W-1:0]   CURVE_MUL   = 13'h103B;
    localparam logic [CURVE_W-1:0] CURVE_FIRST = 14'h103B;
    localparam logic [SEG_W-1:0]   SEG_LAST    = 6'd47;
    localparam logic [IDX_W-1:0]   NO_MATCH    = 11'h600;
    localparam logic [BPOS_W-1:0]  BPOS_TOP    = 3'd4;
    localparam logic [NOTE_O_W-1:0] OCT_NOTES  = 9'd12;
    localparam logic [NOTE_O_W-1:0] NOTE_BIAS  = 9'd144;

    typedef struct packed {
        logic load;
        logic seg_adv;
        logic step_adv;
        logic out_load;
    } t_p2n_cmd;

    typedef struct packed {
        logic seg_hit;
        logic seg_last;
        logic step_last;
    } t_p2n_sts;

endpackage
`default_nettype wire

[hdl/p2n_in_if.sv]
// Interface: input channel carrying pitch word and center note/fine.
`default_nettype none
interface p2n_in_if;
    logic       valid;
    logic       ready;
    logic [15:0] pitch_word;
    logic [6:0]  center_note;
    logic [6:0]  center_fine;

    modport source (output valid, output pitch_word, output center_note,
                    output center_fine, input ready);
    modport sink   (input valid, input pitch_word, input center_note,
                    input center_fine, output ready);
endinterface
`default_nettype wire

[hdl/p2n_out_if.sv]
// Interface: output channel carrying the note and fine result.
`default_nettype none
interface p2n_out_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] note_out;
    logic [7:0]        fine_out;

    modport source (output valid, output note_out, output fine_out, input ready);
    modport sink   (input valid, input note_out, input fine_out, output ready);
endinterface
`default_nettype wire

[hdl/p2n_ctrl.sv]
// Controller: sequences the segment scan, the step search and the result beat.
`default_nettype none
module p2n_ctrl
    import p2n_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire logic     i_out_ready,
    output logic          o_out_valid,
    input  wire t_p2n_sts i_sts,
    output t_p2n_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SEG  = 4'b0010,
        S_STEP = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEG;
                end
            end
            S_SEG: begin
                o_cmd.seg_adv = 1'b1;
                if (i_sts.seg_hit) begin
                    n_state = S_STEP;
                end else if (i_sts.seg_last) begin
                    n_state = S_DONE;
                end
            end
            S_STEP: begin
                o_cmd.step_adv = 1'b1;
                if (i_sts.step_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

[hdl/p2n_dp.sv]
// Datapath: octave encoder, curve multiplier, segment bounds and step search.
`default_nettype none
module p2n_dp
    import p2n_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_p2n_cmd             i_cmd,
    output t_p2n_sts                  o_sts,
    input  wire logic [PITCH_W-1:0]   i_pitch_word,
    input  wire logic [NOTE_W-1:0]    i_center_note,
    input  wire logic [FINE_W-1:0]    i_center_fine,
    output logic signed [NOTE_O_W-1:0] o_note_out,
    output logic [FINE_O_W-1:0]       o_fine_out
);

    logic [PITCH_W-1:0]  r_pitch;
    logic [NOTE_W-1:0]   r_cnote;
    logic [FINE_W-1:0]   r_cfine;
    logic [OCT_W-1:0]    r_oct;
    logic [CURVE_W-1:0]  r_cur;
    logic [CURVE_W-1:0]  r_nxt;
    logic [SEG_W-1:0]    r_seg;
    logic [SPAN_W-1:0]   r_base;
    logic [INC_W-1:0]    r_inc;
    logic [STEP_W-1:0]   r_st;
    logic [BPOS_W-1:0]   r_bpos;
    logic                r_hit;
    logic [NOTE_O_W-1:0] r_note;
    logic [FINE_O_W-1:0] r_fine;

    logic [OCT_W-1:0]          w_oct;
    logic [CURVE_W+MUL_W-1:0]  w_prod;
    logic [SPAN_W-1:0]         w_base;
    logic [SPAN_W-1:0]         w_top;
    logic [INC_W-1:0]          w_inc;
    logic [SPAN_W-1:0]         w_end;
    logic [STEP_W-1:0]         w_cand;
    logic [SPAN_W-1:0]         w_off;
    logic [SPAN_W-1:0]         w_lo;
    logic [PITCH_W:0]          w_pitch_x;
    logic                      w_cand_ok;
    logic [IDX_W-1:0]          w_idx;
    logic [NOTE_O_W-1:0]       w_note;
    logic [FINE_O_W-1:0]       w_fine;

    // octave: position of the highest set bit, zero for a zero pitch
    always_comb begin
        w_oct = '0;
        for (int b = 0; b < PITCH_W; b++) begin
            if (i_pitch_word[b]) begin
                w_oct = OCT_W'(b);
            end
        end
    end

    assign w_pitch_x = {1'b0, r_pitch};

    // segment bounds from the two registered curve points
    assign w_prod  = (CURVE_W + MUL_W)'(r_nxt) * (CURVE_W + MUL_W)'(CURVE_MUL);
    assign w_base  = SPAN_W'(r_cur) << r_oct;
    assign w_top   = SPAN_W'(r_nxt) << r_oct;
    assign w_inc   = INC_W'((w_top - w_base) >> STEP_W);
    assign w_end   = w_base + {w_inc, {STEP_W{1'b0}}};

    assign o_sts.seg_hit   = (w_pitch_x >= w_base[SPAN_W-1:SHIFT])
                          && (w_pitch_x <  w_end[SPAN_W-1:SHIFT]);
    assign o_sts.seg_last  = (r_seg == SEG_LAST);
    assign o_sts.step_last = (r_bpos == '0);

    // binary search for the largest step whose lower bound is at most the pitch
    assign w_cand    = r_st | (STEP_W'(1) << r_bpos);
    assign w_off     = SPAN_W'(w_cand) * SPAN_W'(r_inc);
    assign w_lo      = r_base + w_off;
    assign w_cand_ok = (w_lo[SPAN_W-1:SHIFT] <= w_pitch_x);

    assign w_idx  = r_hit ? {r_seg, r_st} : NO_MATCH;
    assign w_note = NOTE_O_W'(r_cnote) + NOTE_O_W'(w_idx[IDX_W-1:7])
                  + NOTE_O_W'(r_oct) * OCT_NOTES - NOTE_BIAS;
    assign w_fine = FINE_O_W'(r_cfine) + FINE_O_W'(w_idx[6:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pitch <= i_pitch_word;
            r_cnote <= i_center_note;
            r_cfine <= i_center_fine;
            r_oct   <= w_oct;
            r_cur   <= CURVE_START;
            r_nxt   <= CURVE_FIRST;
            r_seg   <= '0;
            r_st    <= '0;
            r_bpos  <= BPOS_TOP;
            r_hit   <= 1'b0;
        end
        if (i_cmd.seg_adv) begin
            if (o_sts.seg_hit) begin
                r_base <= w_base;
                r_inc  <= w_inc;
                r_hit  <= 1'b1;
            end else begin
                // advance to the next segment of the curve
                r_cur <= r_nxt;
                r_nxt <= w_prod[SHIFT+CURVE_W-1:SHIFT];
                r_seg <= r_seg + SEG_W'(1);
            end
        end
        if (i_cmd.step_adv) begin
            if (w_cand_ok) begin
                r_st <= w_cand;
            end
            r_bpos <= r_bpos - BPOS_W'(1);
        end
        if (i_cmd.out_load) begin
            r_note <= w_note;
            r_fine <= w_fine;
        end
    end

    assign o_note_out = $signed(r_note);
    assign o_fine_out = r_fine;

endmodule
`default_nettype wire

[hdl/pitch_to_note_converter.sv]
// Pitch word to note number and fine offset: one item at a time.
// Sequence: the segment scan walks the curve segments (up to 48) with its 13x14
// curve multiplier, a binary step search runs when a segment holds the pitch,
// then the output register loads once the previous result has been taken.
// A new pitch is accepted only when the controller is back in idle.
// Reset (synchronous, active low) returns the controller to idle, output empty.
`default_nettype none
module pitch_to_note_converter
    import p2n_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    p2n_in_if.sink    i_in,
    p2n_out_if.source o_out
);

    t_p2n_cmd w_cmd;
    t_p2n_sts w_sts;

    p2n_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    p2n_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_pitch_word  (i_in.pitch_word),
        .i_center_note (i_in.center_note),
        .i_center_fine (i_in.center_fine),
        .o_note_out    (o_out.note_out),
        .o_fine_out    (o_out.fine_out)
    );

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while a pitch is in flight");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.seg_adv, w_cmd.step_adv, w_cmd.out_load}))
        else $error("controller issued more than one command");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out.valid)
        else $error("result loaded but not presented");

    a_fine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.fine_out != 8'hFF))
        else $error("fine offset out of range");

endmodule
`default_nettype wire

[dv/pitch_to_note_converter_tb.sv]
`timescale 1ns / 100ps
// Testbench: pitch_to_note_converter, directed table then random pitches, checked per beat.
module pitch_to_note_converter_tb;
    import p2n_pkg::*;

    localparam int RAND_PER_PHASE = 475;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 60;
    localparam int DIR_ROWS       = 24;

    typedef struct {
        logic [PITCH_W-1:0]  pitch;
        logic [NOTE_W-1:0]   cnote;
        logic [FINE_W-1:0]   cfine;
        bit                  typed;
        logic [NOTE_O_W-1:0] note;
        logic [FINE_O_W-1:0] fine;
    } t_stim_row;

    typedef struct {
        logic [NOTE_O_W-1:0] note;
        logic [FINE_O_W-1:0] fine;
    } t_note_fine;

    logic i_clk = 1'b0;
    logic i_rst_n;

    p2n_in_if  in_ch ();
    p2n_out_if out_ch ();

    pitch_to_note_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_note_fine  pending_notes[$];
    int          mismatch_cnt = 0;
    int unsigned tx_idle_pct = 16;
    int unsigned rx_idle_pct = 59;
    int unsigned hold_seq = 0;
    int unsigned quiet_cycles = 0;

    // Pitch zero, gap values and the unity pitch per octave are typed in.
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{16'h0000, 7'd0,   7'd0,   1'b1, -9'sd132, 8'd0},
        '{16'h0000, 7'd127, 7'd127, 1'b1, -9'sd5,   8'd127},
        '{16'h1000, 7'd60,  7'd0,   1'b1, 9'd60,    8'd0},
        '{16'h1000, 7'd127, 7'd127, 1'b1, 9'd127,   8'd127},
        '{16'h8000, 7'd127, 7'd127, 1'b1, 9'd163,   8'd127},
        '{16'h8000, 7'd0,   7'd0,   1'b1, 9'd36,    8'd0},
        '{16'hFFFF, 7'd127, 7'd127, 1'b1, 9'd175,   8'd127},
        '{16'hFFFF, 7'd0,   7'd0,   1'b1, 9'd48,    8'd0},
        '{16'h0001, 7'd0,   7'd0,   1'b1, -9'sd132, 8'd0},
        '{16'h0001, 7'd127, 7'd127, 1'b1, -9'sd5,   8'd127},
        '{16'h7FFF, 7'd64,  7'd0,   1'b1, 9'd100,   8'd0},
        '{16'h1FFF, 7'd0,   7'd127, 1'b1, 9'd12,    8'd127},
        '{16'h103B, 7'd60,  7'd64,  1'b0, 9'd0,     8'd0},
        '{16'h4000, 7'd10,  7'd10,  1'b0, 9'd0,     8'd0},
        '{16'h0002, 7'd5,   7'd5,   1'b0, 9'd0,     8'd0},
        '{16'h0003, 7'd5,   7'd5,   1'b0, 9'd0,     8'd0},
        '{16'h1800, 7'd64,  7'd64,  1'b0, 9'd0,     8'd0},
        '{16'h17FF, 7'd64,  7'd64,  1'b0, 9'd0,     8'd0},
        '{16'h5555, 7'd33,  7'd99,  1'b0, 9'd0,     8'd0},
        '{16'hAAAA, 7'd94,  7'd28,  1'b0, 9'd0,     8'd0},
        '{16'h0100, 7'd1,   7'd126, 1'b0, 9'd0,     8'd0},
        '{16'h1FC0, 7'd77,  7'd77,  1'b0, 9'd0,     8'd0},
        '{16'h00FF, 7'd12,  7'd34,  1'b0, 9'd0,     8'd0},
        '{16'hFC00, 7'd100, 7'd3,   1'b0, 9'd0,     8'd0}
    };

    task automatic log_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // Walk the truncated curve: first step whose bounds hold the pitch gives the index.
    function automatic t_note_fine calc_note_fine(input logic [PITCH_W-1:0] pitch,
                                                  input logic [NOTE_W-1:0] cnote,
                                                  input logic [FINE_W-1:0] cfine);
        t_note_fine  res;
        int unsigned oct;
        int unsigned idx;
        bit [31:0]   scale, curve, base, top, inc, a, b;
        bit          found;
        oct = 0;
        for (int k = 0; k < PITCH_W; k++)
            if (pitch[k]) oct = k;
        scale = 32'd1 << oct;
        curve = 32'(CURVE_START);
        idx   = NO_MATCH;
        found = 1'b0;
        for (int seg = 0; seg <= int'(SEG_LAST) && !found; seg++) begin
            base  = scale * curve;
            curve = (curve * 32'(CURVE_MUL)) >> SHIFT;
            top   = scale * curve;
            inc   = (top - base) >> STEP_W;
            a     = 0;
            b     = inc;
            for (int st = 0; st < (1 << STEP_W) && !found; st++) begin
                if (32'(pitch) >= ((base + a) >> SHIFT) && 32'(pitch) < ((base + b) >> SHIFT)) begin
                    idx   = (seg << STEP_W) + st;
                    found = 1'b1;
                end
                a += inc;
                b += inc;
            end
        end
        res.note = NOTE_O_W'(cnote + idx / (1 << FINE_W) + oct * OCT_NOTES - NOTE_BIAS);
        res.fine = FINE_O_W'(cfine + idx % (1 << FINE_W));
        return res;
    endfunction

    function automatic logic [PITCH_W-1:0] rand_pitch();
        int unsigned oct;
        bit [31:0]   span;
        oct  = $urandom_range(PITCH_W - 1);
        span = 32'd1 << oct;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return PITCH_W'(span | ($urandom & (span - 1)));
            5, 6:          return PITCH_W'($urandom);
            // top sliver of the octave sits above the curve end
            7:             return PITCH_W'((span << 1) - 1 - $urandom_range(span >> 6));
            8:             return PITCH_W'($urandom_range(15));
            default:       return PITCH_W'(32'h1000 + $urandom_range(64) - 32);
        endcase
    endfunction

    // Call at a falling edge; returns at the falling edge after the beat.
    task automatic send_beat(input t_stim_row row);
        t_note_fine exp_res;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.pitch_word  = row.pitch;
        in_ch.center_note = row.cnote;
        in_ch.center_fine = row.cfine;
        do @(posedge i_clk); while (!in_ch.ready);
        if (row.typed) begin
            exp_res.note = row.note;
            exp_res.fine = row.fine;
        end else begin
            exp_res = calc_note_fine(row.pitch, row.cnote, row.cfine);
        end
        pending_notes.push_back(exp_res);
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, plus a long hold-off each time hold_seq moves.
    initial begin : result_sink
        int unsigned hold_seen;
        hold_seen    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_seq) begin
                hold_seen    = hold_seq;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_note_fine want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_notes.size() == 0) begin
                log_mismatch($sformatf("result note=%0d fine=%0d with nothing pending",
                                       out_ch.note_out, out_ch.fine_out));
            end else begin
                want = pending_notes.pop_front();
                if (out_ch.note_out !== want.note)
                    log_mismatch($sformatf("note_out got %0d expected %0d",
                                           out_ch.note_out, $signed(want.note)));
                if (out_ch.fine_out !== want.fine)
                    log_mismatch($sformatf("fine_out got %0d expected %0d",
                                           out_ch.fine_out, want.fine));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        t_stim_row row;
        in_ch.valid       = 1'b0;
        in_ch.pitch_word  = '0;
        in_ch.center_note = '0;
        in_ch.center_fine = '0;
        i_rst_n           = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_beat(dir_rows[i]);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin tx_idle_pct = 16; rx_idle_pct = 59; end
                1:       begin tx_idle_pct = 59; rx_idle_pct = 16; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            // fill the block against a stalled receiver
            if (ph == 0)
                hold_seq++;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (ph == 1 && n == RAND_PER_PHASE / 2) begin
                    in_ch.valid = 1'b0;
                    while (pending_notes.size() != 0) @(negedge i_clk);
                end
                row.pitch = rand_pitch();
                row.cnote = NOTE_W'($urandom_range(127));
                row.cfine = FINE_W'($urandom_range(127));
                row.typed = 1'b0;
                row.note  = '0;
                row.fine  = '0;
                send_beat(row);
            end
        end
        in_ch.valid = 1'b0;

        while (pending_notes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
